/* src/pcg_pkg.sv */
// Package for the plasma color generator: widths, phase constants, command and
// status structs, and the quarter-wave sine table with its lookup function.
// Used by every module of the block; depends on nothing.
`default_nettype none
package pcg_pkg;

  localparam int unsigned LEVEL_MAX        = 4095;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned STEP_WRAP        = 200000;

  localparam int unsigned PHASE_PERIOD = 2000;
  localparam int unsigned STEP_W       = $clog2(STEP_WRAP);
  localparam int unsigned PHASE_W      = $clog2(PHASE_PERIOD);
  localparam int unsigned IDX_W        = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned J_W          = IDX_W - 2;
  localparam int unsigned QUARTER      = SINE_TABLE_DEPTH / 4;

  localparam int unsigned AMP_W   = 11;
  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned BANK_W  = 2;
  localparam int unsigned WAVE_W  = 16;
  localparam int unsigned PROD_W  = AMP_W + WAVE_W;
  localparam int unsigned SUM_W   = PROD_W - 14 + 1;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  // base phase advances by 2^32 / PHASE_PERIOD per step, split into whole and fraction
  localparam logic [63:0] TURN       = 64'd1 << 32;
  localparam logic [31:0] STEP_INC   = 32'(TURN / PHASE_PERIOD);
  localparam logic [PHASE_W:0] STEP_FRAC = (PHASE_W + 1)'(TURN % PHASE_PERIOD);
  localparam logic [PHASE_W:0] FRAC_WRAP = (PHASE_W + 1)'(PHASE_PERIOD);

  localparam logic [31:0] BANK_PHASE [3] = '{32'd0, 32'd2540685460, 32'd786403624};
  // blue, green, red, white
  localparam logic [31:0] COLOR_PHASE [4] =
    '{32'd2863311531, 32'd1431655765, 32'd0, 32'd1431655765};

  localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_AMPLITUDE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_OFFSET     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_AMPLITUDE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_OFFSET    = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RED_AMPLITUDE   = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_RED_OFFSET      = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_WHITE_AMPLITUDE = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_WHITE_OFFSET    = 8'd7;

  localparam logic [1:0] COLOR_BLUE  = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_RED   = 2'd2;
  localparam logic [1:0] COLOR_WHITE = 2'd3;

  localparam logic [BANK_W-1:0] LAST_BANK = 2'd2;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] TAY_C1  = 64'd1686629713;
  localparam logic [63:0] TAY_C3  = 64'd693598668;
  localparam logic [63:0] TAY_C5  = 64'd85569306;
  localparam logic [63:0] TAY_C7  = 64'd5026993;
  localparam logic [63:0] TAY_C9  = 64'd172272;

  localparam logic [WAVE_W-1:0] SIN_ONE = 16'd16384;

  typedef struct packed {
    logic              step;
    logic              inner;
    logic              look;
    logic              mul;
    logic              load;
    logic              last;
    logic [BANK_W-1:0] bank;
    logic [1:0]        look_color;
    logic [1:0]        mul_color;
  } pcg_cmd_t;

  typedef struct packed {
    logic out_free;
  } pcg_status_t;

  typedef logic [14:0] quarter_table_t [QUARTER];

  // sin(pi/2 * x) for x in Q30, Q14 result rounded and capped
  function automatic logic [14:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] v;
    x2 = (x * x) >> 30;
    p = TAY_C7 - ((x2 * TAY_C9) >> 30);
    p = TAY_C5 - ((x2 * p) >> 30);
    p = TAY_C3 - ((x2 * p) >> 30);
    p = TAY_C1 - ((x2 * p) >> 30);
    v = (x * p) >> 30;
    v = (v + 64'd32768) >> 16;
    if (v > 64'd16384) begin
      v = 64'd16384;
    end
    return v[14:0];
  endfunction

  function automatic quarter_table_t build_quarter_table();
    quarter_table_t t;
    for (int j = 0; j < QUARTER; j++) begin
      t[j] = quarter_sine((64'(j) << 32) / SINE_TABLE_DEPTH);
    end
    return t;
  endfunction

  localparam quarter_table_t QUARTER_TABLE = build_quarter_table();
  localparam logic [14:0]    QUARTER_PEAK  = quarter_sine(Q30_ONE);

  // Q1.14 sine of a Q0.32 full-turn phase
  function automatic logic signed [WAVE_W-1:0] sine_lookup(input logic [31:0] phase);
    logic [IDX_W-1:0] k;
    logic [1:0]       quad;
    logic [J_W-1:0]   j;
    logic [14:0]      mag;
    k    = phase[31 -: IDX_W];
    quad = k[IDX_W-1 -: 2];
    j    = k[J_W-1:0];
    if (!quad[0]) begin
      mag = QUARTER_TABLE[j];
    end else if (j == '0) begin
      mag = QUARTER_PEAK;
    end else begin
      mag = QUARTER_TABLE[J_W'(~j + 1'b1)];
    end
    if (quad[1]) begin
      return -$signed({1'b0, mag});
    end
    return $signed({1'b0, mag});
  endfunction

endpackage
`default_nettype wire

/* src/plasma_color_generator_top.sv */
// Plasma color generator for three LED banks. Each tick transfer with tick set
// advances the animation step and yields three result transfers, banks 0, 1
// and 2, the last one flagged by tlast; a tick transfer with tick clear is
// taken and yields nothing. Ticks are held off while banks are in work; per
// bank the sequencer does one inner sine lookup, four outer lookups overlapped
// with the amplitude multiply, one multiply drain and a load of the output
// register, which waits until the result side is free. The single sine table
// and the single multiplier are shared by all lookups. A new tick is taken
// while the third result still waits in the output register.
// Configuration writes are always ready and take effect at once.
// Top level; instantiates pcg_ctrl and pcg_datapath, uses pcg_pkg.
`default_nettype none
module plasma_color_generator_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [pcg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] tick, rest zero
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [1:0] bank_index, [13:2] blue_level, [25:14] green_level,
  // [37:26] red_level, [49:38] white_level, rest zero
  output logic [pcg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,  // last_of_tick
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pcg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pcg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcg_pkg::*;

  pcg_cmd_t    cmd;
  pcg_status_t status;

  assign cfg_ready = 1'b1;

  pcg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (s_axis_tvalid),
    .tick       (s_axis_tdata[0]),
    .tick_ready (s_axis_tready),
    .status     (status),
    .cmd        (cmd)
  );

  pcg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
`default_nettype wire

/* src/pcg_ctrl.sv */
// Sequencer of the plasma color generator: takes ticks and steps the datapath
// through one inner and four outer sine lookups per bank. Depends on pcg_pkg.
`default_nettype none
module pcg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 tick_valid,
  input  wire logic                 tick,
  output logic                      tick_ready,
  input  wire pcg_pkg::pcg_status_t status,
  output pcg_pkg::pcg_cmd_t         cmd
);
  import pcg_pkg::*;

  typedef enum logic [2:0] {IDLE, INNER, COLOR, DRAIN, EMIT} state_t;

  state_t            state;
  logic [BANK_W-1:0] bank;
  logic [1:0]        color;

  assign tick_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    cmd.bank = bank;
    cmd.look_color = color;
    cmd.mul_color = color - 2'd1;
    cmd.last = (bank == LAST_BANK);
    case (state)
      IDLE: begin
        cmd.step = tick_valid && tick;
      end
      INNER: begin
        cmd.inner = 1'b1;
      end
      COLOR: begin
        cmd.look = 1'b1;
        cmd.mul = (color != COLOR_BLUE);
      end
      DRAIN: begin
        cmd.mul = 1'b1;
        cmd.mul_color = COLOR_WHITE;
      end
      EMIT: begin
        cmd.load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      bank  <= '0;
      color <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (tick_valid && tick) begin
            state <= INNER;
            bank  <= '0;
          end
        end
        INNER: begin
          state <= COLOR;
          color <= COLOR_BLUE;
        end
        COLOR: begin
          color <= color + 2'd1;
          if (color == COLOR_WHITE) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= EMIT;
        end
        EMIT: begin
          if (status.out_free) begin
            if (bank == LAST_BANK) begin
              state <= IDLE;
            end else begin
              bank  <= bank + 1'b1;
              state <= INNER;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/pcg_datapath.sv */
// Datapath of the plasma color generator: step and phase counters, config
// registers, shared sine table, shared multiplier and the output register.
// Depends on pcg_pkg.
`default_nettype none
module pcg_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pcg_pkg::pcg_cmd_t                  cmd,
  output pcg_pkg::pcg_status_t                    status,
  input  wire logic                               cfg_we,
  input  wire logic [pcg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [pcg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [pcg_pkg::OUT_TDATA_W-1:0]         out_data,
  output logic                                    out_last
);
  import pcg_pkg::*;

  logic [STEP_W-1:0]  step_count;
  logic [PHASE_W-1:0] phase_count;
  logic [PHASE_W-1:0] frac;
  logic [31:0]        base;
  logic [PHASE_W:0]   frac_sum;

  logic [AMP_W-1:0]   amp [4];
  logic [LEVEL_W-1:0] off [4];
  logic [LEVEL_W-1:0] level [4];

  logic signed [WAVE_W-1:0] inner_s;
  logic [WAVE_W-1:0]        wave;
  logic [31:0]              lookup_phase;
  logic signed [WAVE_W-1:0] sin_val;
  logic [PROD_W-1:0]        prod;
  logic [SUM_W-1:0]         sum;

  assign status.out_free = !out_valid || out_ready;
  assign frac_sum = {1'b0, frac} + STEP_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count  <= '0;
      phase_count <= '0;
      frac        <= '0;
      base        <= '0;
    end else if (cmd.step) begin
      if (step_count == STEP_W'(STEP_WRAP - 1)) begin
        step_count  <= '0;
        phase_count <= '0;
        frac        <= '0;
        base        <= '0;
      end else begin
        step_count <= step_count + 1'b1;
        if (phase_count == PHASE_W'(PHASE_PERIOD - 1)) begin
          phase_count <= '0;
          frac        <= '0;
          base        <= '0;
        end else begin
          phase_count <= phase_count + 1'b1;
          if (frac_sum >= FRAC_WRAP) begin
            frac <= PHASE_W'(frac_sum - FRAC_WRAP);
            base <= base + STEP_INC + 32'd1;
          end else begin
            frac <= PHASE_W'(frac_sum);
            base <= base + STEP_INC;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        amp[i] <= '0;
        off[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLUE_AMPLITUDE:  amp[COLOR_BLUE]  <= cfg_data[AMP_W-1:0];
        CFG_BLUE_OFFSET:     off[COLOR_BLUE]  <= cfg_data[LEVEL_W-1:0];
        CFG_GREEN_AMPLITUDE: amp[COLOR_GREEN] <= cfg_data[AMP_W-1:0];
        CFG_GREEN_OFFSET:    off[COLOR_GREEN] <= cfg_data[LEVEL_W-1:0];
        CFG_RED_AMPLITUDE:   amp[COLOR_RED]   <= cfg_data[AMP_W-1:0];
        CFG_RED_OFFSET:      off[COLOR_RED]   <= cfg_data[LEVEL_W-1:0];
        CFG_WHITE_AMPLITUDE: amp[COLOR_WHITE] <= cfg_data[AMP_W-1:0];
        CFG_WHITE_OFFSET:    off[COLOR_WHITE] <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // one table serves both the inner and the outer wave
  always_comb begin
    if (cmd.inner) begin
      lookup_phase = base + BANK_PHASE[cmd.bank];
    end else begin
      lookup_phase = {inner_s[14:0], 17'd0} + COLOR_PHASE[cmd.look_color];
    end
  end

  assign sin_val = sine_lookup(lookup_phase);
  assign prod    = PROD_W'(amp[cmd.mul_color]) * PROD_W'(wave);
  assign sum     = SUM_W'(prod[PROD_W-1:14]) + SUM_W'(off[cmd.mul_color]);

  always_ff @(posedge clk) begin
    if (cmd.inner) begin
      inner_s <= sin_val;
    end
    if (cmd.look) begin
      wave <= WAVE_W'(sin_val) + SIN_ONE;
    end
    if (cmd.mul) begin
      if (sum > SUM_W'(LEVEL_MAX)) begin
        level[cmd.mul_color] <= LEVEL_W'(LEVEL_MAX);
      end else begin
        level[cmd.mul_color] <= sum[LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= {6'd0, level[COLOR_WHITE], level[COLOR_RED], level[COLOR_GREEN],
                   level[COLOR_BLUE], cmd.bank};
      out_last <= cmd.last;
    end
  end

endmodule
`default_nettype wire

/* src/pcg_checker.sv */
// Port-level checks for the plasma color generator, bound to the top level.
// Uses pcg_pkg for widths.
`default_nettype none
module pcg_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [pcg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [pcg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tlast
);
  import pcg_pkg::*;

  // tlast marks exactly the third bank
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == LAST_BANK)))
    else $error("tlast does not match last bank");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("bank index out of range");

  // a tick with work holds off the next tick
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) |=> !s_axis_tready)
    else $error("tick taken while banks still in progress");

  // no result starts while the block is waiting for ticks
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result appeared without a tick");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind plasma_color_generator_top pcg_checker u_pcg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
